// ===== rtl/dsc_pkg.sv =====
`default_nettype none
package dsc_pkg;

    localparam int WORD_BITS    = 32;
    localparam int CNT_BITS     = $clog2(WORD_BITS + 1);
    localparam int CFG_IDX_BITS = 2;
    localparam int VERDICT_BITS = 3;

    typedef logic [WORD_BITS-1:0] word_t;

    localparam logic [VERDICT_BITS-1:0] VERDICT_VALID    = 3'd0;
    localparam logic [VERDICT_BITS-1:0] VERDICT_MISMATCH = 3'd1;
    localparam logic [VERDICT_BITS-1:0] VERDICT_R_RANGE  = 3'd2;
    localparam logic [VERDICT_BITS-1:0] VERDICT_S_RANGE  = 3'd3;
    localparam logic [VERDICT_BITS-1:0] VERDICT_NO_INV   = 3'd4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS_P   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORDER_Q     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GENERATOR_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PUBLIC_KEY  = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_HDIV,
        OP_INIT_R1,
        OP_EUC_DIV,
        OP_EUC_MUL,
        OP_EUC_UPD,
        OP_U1,
        OP_U2,
        OP_SAVE_U2,
        OP_BASE_A,
        OP_BASE_Y,
        OP_POW_INIT,
        OP_SQ,
        OP_ACC_WR,
        OP_MB,
        OP_SHIFT,
        OP_SAVE_X1,
        OP_FIN_MUL,
        OP_FIN_DIV
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic r_bad;
        logic s_bad;
        logic r1_zero;
        logic r0_one;
        logic ebit;
        logic cnt_last;
        logic p_small;
        logic match;
    } dp_status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_HWAIT,
        S_EINIT,
        S_ETEST,
        S_EDWAIT,
        S_EMUL,
        S_EMWAIT,
        S_EUPD,
        S_U1WAIT,
        S_U2,
        S_U2WAIT,
        S_U2SAVE,
        S_PCHK,
        S_BWAIT,
        S_PINIT,
        S_SQ,
        S_SQWAIT,
        S_SQWR,
        S_MB,
        S_MBWAIT,
        S_MBWR,
        S_SHIFT,
        S_POWEND,
        S_BASEY,
        S_FMWAIT,
        S_FDIV,
        S_FDWAIT,
        S_CMP,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/dsc_datapath.sv =====
`default_nettype none
module dsc_datapath
    import dsc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire dp_cmd_t                 cmd,
    output dp_status_t                   status,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire word_t                   cfg_data,
    input  wire word_t                   sig_r,
    input  wire word_t                   sig_s,
    input  wire word_t                   hash_value
);

    word_t p_reg, q_reg, a_reg, y_reg;
    word_t p_next, q_next, a_next, y_next;
    word_t r_reg, s_reg, h_reg, r_next, s_next, h_next;
    word_t r0_reg, r1_reg, t0_reg, t1_reg, rn_reg;
    word_t r0_next, r1_next, t0_next, t1_next, rn_next;
    word_t u1_reg, u2_reg, e_reg, base_reg, acc_reg, x1_reg;
    word_t u1_next, u2_next, e_next, base_next, acc_next, x1_next;
    logic [CNT_BITS-1:0] pcnt_reg, pcnt_next;
    word_t ua_reg, ub_reg, um_reg, uacc_reg;
    word_t ua_next, ub_next, um_next, uacc_next;
    logic [CNT_BITS-1:0] ucnt_reg, ucnt_next;
    logic uphase_reg, uphase_next, umul_reg, umul_next;

    logic           start, st_mul;
    word_t          st_a, st_b, st_m;
    logic [WORD_BITS:0] rem2, diff, dbl, sum;
    word_t          qred, tn;

    always_comb
    begin
        qred = (ua_reg >= q_reg) ? (ua_reg - q_reg) : ua_reg;
        tn   = (t0_reg >= uacc_reg) ? (t0_reg - uacc_reg) : (t0_reg - uacc_reg + q_reg);
    end

    always_comb
    begin
        p_next = p_reg; q_next = q_reg; a_next = a_reg; y_next = y_reg;
        r_next = r_reg; s_next = s_reg; h_next = h_reg;
        r0_next = r0_reg; r1_next = r1_reg; t0_next = t0_reg; t1_next = t1_reg;
        rn_next = rn_reg; u1_next = u1_reg; u2_next = u2_reg; e_next = e_reg;
        base_next = base_reg; acc_next = acc_reg; x1_next = x1_reg;
        pcnt_next = pcnt_reg;
        ua_next = ua_reg; ub_next = ub_reg; um_next = um_reg; uacc_next = uacc_reg;
        ucnt_next = ucnt_reg; uphase_next = uphase_reg; umul_next = umul_reg;
        start = 1'b0; st_mul = 1'b0; st_a = '0; st_b = '0; st_m = q_reg;
        rem2 = '0; diff = '0; dbl = '0; sum = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODULUS_P:   p_next = cfg_data;
                CFG_ORDER_Q:     q_next = cfg_data;
                CFG_GENERATOR_A: a_next = cfg_data;
                CFG_PUBLIC_KEY:  y_next = cfg_data;
                default:         p_next = p_reg;
            endcase
        end

        if (ucnt_reg != '0)
        begin
            if (!umul_reg)
            begin
                rem2 = {uacc_reg, ua_reg[WORD_BITS-1]};
                diff = rem2 - {1'b0, um_reg};
                if (rem2 >= {1'b0, um_reg})
                begin
                    uacc_next = diff[WORD_BITS-1:0];
                    ua_next   = {ua_reg[WORD_BITS-2:0], 1'b1};
                end
                else
                begin
                    uacc_next = rem2[WORD_BITS-1:0];
                    ua_next   = {ua_reg[WORD_BITS-2:0], 1'b0};
                end
                ucnt_next = ucnt_reg - 1'b1;
            end
            else if (!uphase_reg)
            begin
                dbl = {uacc_reg, 1'b0};
                uacc_next = (dbl >= {1'b0, um_reg}) ? (dbl[WORD_BITS-1:0] - um_reg)
                                                    : dbl[WORD_BITS-1:0];
                uphase_next = 1'b1;
            end
            else
            begin
                sum = {1'b0, uacc_reg} + (ub_reg[WORD_BITS-1] ? {1'b0, ua_reg} : '0);
                uacc_next = (sum >= {1'b0, um_reg}) ? (sum[WORD_BITS-1:0] - um_reg)
                                                    : sum[WORD_BITS-1:0];
                ub_next = {ub_reg[WORD_BITS-2:0], 1'b0};
                uphase_next = 1'b0;
                ucnt_next = ucnt_reg - 1'b1;
            end
        end

        case (cmd.op)
            OP_LOAD:
            begin
                r_next = sig_r; s_next = sig_s; h_next = hash_value;
            end
            OP_HDIV:
            begin
                start = 1'b1; st_a = h_reg; st_m = q_reg;
            end
            OP_INIT_R1:
            begin
                r0_next = q_reg; r1_next = uacc_reg;
                t0_next = '0; t1_next = word_t'(1);
            end
            OP_EUC_DIV:
            begin
                start = 1'b1; st_a = r0_reg; st_m = r1_reg;
            end
            OP_EUC_MUL:
            begin
                rn_next = uacc_reg;
                start = 1'b1; st_mul = 1'b1; st_a = qred; st_b = t1_reg; st_m = q_reg;
            end
            OP_EUC_UPD:
            begin
                r0_next = r1_reg; r1_next = rn_reg; t0_next = t1_reg; t1_next = tn;
            end
            OP_U1:
            begin
                start = 1'b1; st_mul = 1'b1; st_a = s_reg; st_b = t0_reg; st_m = q_reg;
            end
            OP_U2:
            begin
                u1_next = uacc_reg;
                start = 1'b1; st_mul = 1'b1; st_a = q_reg - r_reg; st_b = t0_reg;
                st_m = q_reg;
            end
            OP_SAVE_U2: u2_next = uacc_reg;
            OP_BASE_A:
            begin
                e_next = u1_reg; start = 1'b1; st_a = a_reg; st_m = p_reg;
            end
            OP_BASE_Y:
            begin
                e_next = u2_reg; start = 1'b1; st_a = y_reg; st_m = p_reg;
            end
            OP_POW_INIT:
            begin
                base_next = uacc_reg; acc_next = word_t'(1);
                pcnt_next = CNT_BITS'(WORD_BITS);
            end
            OP_SQ:
            begin
                start = 1'b1; st_mul = 1'b1; st_a = acc_reg; st_b = acc_reg; st_m = p_reg;
            end
            OP_ACC_WR: acc_next = uacc_reg;
            OP_MB:
            begin
                start = 1'b1; st_mul = 1'b1; st_a = acc_reg; st_b = base_reg; st_m = p_reg;
            end
            OP_SHIFT:
            begin
                e_next = {e_reg[WORD_BITS-2:0], 1'b0}; pcnt_next = pcnt_reg - 1'b1;
            end
            OP_SAVE_X1: x1_next = acc_reg;
            OP_FIN_MUL:
            begin
                start = 1'b1; st_mul = 1'b1; st_a = x1_reg; st_b = acc_reg; st_m = p_reg;
            end
            OP_FIN_DIV:
            begin
                start = 1'b1; st_a = uacc_reg; st_m = q_reg;
            end
            default: start = 1'b0;
        endcase

        if (start)
        begin
            ua_next = st_a; ub_next = st_b; um_next = st_m; uacc_next = '0;
            ucnt_next = CNT_BITS'(WORD_BITS); uphase_next = 1'b0; umul_next = st_mul;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= word_t'(2); q_reg <= word_t'(2);
            a_reg <= word_t'(1); y_reg <= word_t'(1);
            r_reg <= '0; s_reg <= '0; h_reg <= '0;
            r0_reg <= '0; r1_reg <= '0; t0_reg <= '0; t1_reg <= '0; rn_reg <= '0;
            u1_reg <= '0; u2_reg <= '0; e_reg <= '0; base_reg <= '0;
            acc_reg <= '0; x1_reg <= '0; pcnt_reg <= '0;
            ua_reg <= '0; ub_reg <= '0; um_reg <= '0; uacc_reg <= '0;
            ucnt_reg <= '0; uphase_reg <= 1'b0; umul_reg <= 1'b0;
        end
        else
        begin
            p_reg <= p_next; q_reg <= q_next; a_reg <= a_next; y_reg <= y_next;
            r_reg <= r_next; s_reg <= s_next; h_reg <= h_next;
            r0_reg <= r0_next; r1_reg <= r1_next; t0_reg <= t0_next;
            t1_reg <= t1_next; rn_reg <= rn_next;
            u1_reg <= u1_next; u2_reg <= u2_next; e_reg <= e_next;
            base_reg <= base_next; acc_reg <= acc_next; x1_reg <= x1_next;
            pcnt_reg <= pcnt_next;
            ua_reg <= ua_next; ub_reg <= ub_next; um_reg <= um_next;
            uacc_reg <= uacc_next; ucnt_reg <= ucnt_next;
            uphase_reg <= uphase_next; umul_reg <= umul_next;
        end
    end

    always_comb
    begin
        status.busy     = (ucnt_reg != '0);
        status.r_bad    = (r_reg == '0) || (r_reg >= q_reg);
        status.s_bad    = (s_reg == '0) || (s_reg >= q_reg);
        status.r1_zero  = (r1_reg == '0);
        status.r0_one   = (r0_reg == word_t'(1));
        status.ebit     = e_reg[WORD_BITS-1];
        status.cnt_last = (pcnt_reg == CNT_BITS'(1));
        status.p_small  = (p_reg < word_t'(2));
        status.match    = (uacc_reg == r_reg);
    end

endmodule
`default_nettype wire

// ===== rtl/dsc_ctrl.sv =====
`default_nettype none
module dsc_ctrl
    import dsc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [VERDICT_BITS-1:0]      verdict,
    output dp_cmd_t                      cmd,
    input  wire dp_status_t              status
);

    state_t state_reg, state_next;
    logic   pass2_reg, pass2_next;
    logic   out_valid_reg, out_valid_next;
    logic [VERDICT_BITS-1:0] res_reg, res_next, verdict_reg, verdict_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
            verdict_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pass2_reg     <= pass2_next;
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
            verdict_reg   <= verdict_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pass2_next     = pass2_reg;
        res_next       = res_reg;
        verdict_next   = verdict_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = OP_NONE;
        in_stall       = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.r_bad)
                begin
                    res_next = VERDICT_R_RANGE; state_next = S_DONE;
                end
                else if (status.s_bad)
                begin
                    res_next = VERDICT_S_RANGE; state_next = S_DONE;
                end
                else
                begin
                    cmd.op = OP_HDIV; state_next = S_HWAIT;
                end
            end
            S_HWAIT:  if (!status.busy) state_next = S_EINIT;
            S_EINIT:
            begin
                cmd.op = OP_INIT_R1; state_next = S_ETEST;
            end
            S_ETEST:
            begin
                if (status.r1_zero)
                begin
                    if (status.r0_one)
                    begin
                        cmd.op = OP_U1; state_next = S_U1WAIT;
                    end
                    else
                    begin
                        res_next = VERDICT_NO_INV; state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.op = OP_EUC_DIV; state_next = S_EDWAIT;
                end
            end
            S_EDWAIT: if (!status.busy) state_next = S_EMUL;
            S_EMUL:
            begin
                cmd.op = OP_EUC_MUL; state_next = S_EMWAIT;
            end
            S_EMWAIT: if (!status.busy) state_next = S_EUPD;
            S_EUPD:
            begin
                cmd.op = OP_EUC_UPD; state_next = S_ETEST;
            end
            S_U1WAIT: if (!status.busy) state_next = S_U2;
            S_U2:
            begin
                cmd.op = OP_U2; state_next = S_U2WAIT;
            end
            S_U2WAIT: if (!status.busy) state_next = S_U2SAVE;
            S_U2SAVE:
            begin
                cmd.op = OP_SAVE_U2; state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (status.p_small)
                begin
                    res_next = VERDICT_MISMATCH; state_next = S_DONE;
                end
                else
                begin
                    cmd.op = OP_BASE_A; pass2_next = 1'b0; state_next = S_BWAIT;
                end
            end
            S_BWAIT:  if (!status.busy) state_next = S_PINIT;
            S_PINIT:
            begin
                cmd.op = OP_POW_INIT; state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.op = OP_SQ; state_next = S_SQWAIT;
            end
            S_SQWAIT: if (!status.busy) state_next = S_SQWR;
            S_SQWR:
            begin
                cmd.op = OP_ACC_WR;
                state_next = status.ebit ? S_MB : S_SHIFT;
            end
            S_MB:
            begin
                cmd.op = OP_MB; state_next = S_MBWAIT;
            end
            S_MBWAIT: if (!status.busy) state_next = S_MBWR;
            S_MBWR:
            begin
                cmd.op = OP_ACC_WR; state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.op = OP_SHIFT;
                state_next = status.cnt_last ? S_POWEND : S_SQ;
            end
            S_POWEND:
            begin
                if (!pass2_reg)
                begin
                    cmd.op = OP_SAVE_X1; state_next = S_BASEY;
                end
                else
                begin
                    cmd.op = OP_FIN_MUL; state_next = S_FMWAIT;
                end
            end
            S_BASEY:
            begin
                cmd.op = OP_BASE_Y; pass2_next = 1'b1; state_next = S_BWAIT;
            end
            S_FMWAIT: if (!status.busy) state_next = S_FDIV;
            S_FDIV:
            begin
                cmd.op = OP_FIN_DIV; state_next = S_FDWAIT;
            end
            S_FDWAIT: if (!status.busy) state_next = S_CMP;
            S_CMP:
            begin
                res_next = status.match ? VERDICT_VALID : VERDICT_MISMATCH;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    verdict_next   = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

endmodule
`default_nettype wire

// ===== rtl/dsa_signature_checker_top.sv =====
`default_nettype none
// Verifies a GOST R 34.10-94 style signature (sig_r, sig_s) against hash_value using the
// domain values p, q, a and public key y held in the configuration registers, and returns
// one verdict per request. A range rejection goes from S_CHECK straight to S_DONE without
// any arithmetic, and the next request can be taken once the controller is back in S_IDLE.
// A full check takes an extended Euclid inverse mod q (one restoring division and one
// modular product per step), two modular products for u1 and u2, and two exponentiations
// by square-and-multiply over the full word. Its running time depends on the number of
// Euclid steps and the set bits of the exponents, and it is set by the single shared
// arithmetic unit: a restoring divider at one bit per cycle and an interleaved modular
// multiplier that doubles and then adds for each multiplier bit. One request is in work
// at a time; a new request is taken while the previous verdict still waits at the
// output.
module dsa_signature_checker_top
    import dsc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [WORD_BITS-1:0]    cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [WORD_BITS-1:0]    sig_r,
    input  wire logic [WORD_BITS-1:0]    sig_s,
    input  wire logic [WORD_BITS-1:0]    hash_value,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [VERDICT_BITS-1:0]      verdict
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    dsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .verdict   (verdict),
        .cmd       (cmd),
        .status    (status)
    );

    dsc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sig_r      (sig_r),
        .sig_s      (sig_s),
        .hash_value (hash_value)
    );

endmodule
`default_nettype wire

// ===== rtl/dsc_checker.sv =====
`default_nettype none
module dsc_checker
    import dsc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic                    in_stall,
    input  wire logic                    out_valid,
    input  wire logic                    out_stall,
    input  wire logic [VERDICT_BITS-1:0] verdict
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("verdict withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(verdict))
        else $error("verdict changed while stalled");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict <= VERDICT_NO_INV))
        else $error("verdict code out of range");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while one is in work");

endmodule

bind dsa_signature_checker_top dsc_checker u_dsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .verdict   (verdict)
);
`default_nettype wire

// ===== tb/sv/dsa_signature_checker_top_test.sv =====
`default_nettype none
module dsa_signature_checker_top_test;
    import dsc_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct {
        word_t                   r;
        word_t                   s;
        word_t                   h;
        bit                      typed;
        logic [VERDICT_BITS-1:0] want;
    } sig_row_t;

    localparam int IDLE_LIMIT = 200000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = CFG_MODULUS_P;
    word_t                   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    word_t                   sig_r = '0;
    word_t                   sig_s = '0;
    word_t                   hash_value = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b1;
    logic [VERDICT_BITS-1:0] verdict;

    u64_t mod_p, mod_q, gen_a, pub_y, secret_x;
    logic [VERDICT_BITS-1:0] pending_verdicts[$];
    int   failures = 0;
    int   idle_cycles = 0;
    bit   calm = 1'b0;

    dsa_signature_checker_top uut (.*);

    always #1 clk = ~clk;

    function automatic u64_t mul_mod(input u64_t x, input u64_t y, input u64_t m);
        return ((x % m) * (y % m)) % m;
    endfunction

    function automatic u64_t pow_mod(input u64_t b, input u64_t e, input u64_t m);
        u64_t acc;
        acc = 1 % m;
        b = b % m;
        while (e != 0)
        begin
            if (e[0])
                acc = mul_mod(acc, b, m);
            b = mul_mod(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic bit inverse_mod(input u64_t x, input u64_t m, output u64_t w);
        u64_t r0, r1, t0, t1, quot, rn, prod, tn;
        r0 = m;
        r1 = x % m;
        t0 = 0;
        t1 = 1;
        while (r1 != 0)
        begin
            quot = r0 / r1;
            rn = r0 - quot * r1;
            prod = mul_mod(quot, t1, m);
            tn = (t0 >= prod) ? t0 - prod : t0 + (m - prod);
            r0 = r1;
            r1 = rn;
            t0 = t1;
            t1 = tn;
        end
        w = t0 % m;
        return r0 == 1;
    endfunction

    function automatic logic [VERDICT_BITS-1:0] predict_verdict(input u64_t r, input u64_t s,
                                                                input u64_t h);
        u64_t w, u1, u2, v;
        if (r == 0 || r >= mod_q)
            return VERDICT_R_RANGE;
        if (s == 0 || s >= mod_q)
            return VERDICT_S_RANGE;
        if (!inverse_mod(h, mod_q, w))
            return VERDICT_NO_INV;
        u1 = mul_mod(s, w, mod_q);
        u2 = mul_mod(mod_q - r, w, mod_q);
        if (mod_p < 2)
            v = 0;
        else
            v = mul_mod(pow_mod(gen_a, u1, mod_p), pow_mod(pub_y, u2, mod_p), mod_p) % mod_q;
        return (v == r) ? VERDICT_VALID : VERDICT_MISMATCH;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input word_t value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_MODULUS_P:   mod_p = value;
            CFG_ORDER_Q:     mod_q = value;
            CFG_GENERATOR_A: gen_a = value;
            default:         pub_y = value;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic configure(input u64_t p, input u64_t q, input u64_t a, input u64_t y);
        drain();
        write_reg(CFG_MODULUS_P, word_t'(p));
        write_reg(CFG_ORDER_Q, word_t'(q));
        write_reg(CFG_GENERATOR_A, word_t'(a));
        write_reg(CFG_PUBLIC_KEY, word_t'(y));
    endtask

    // The caller is at a falling edge; the request is held until it is taken.
    task automatic send_request(input word_t r, input word_t s, input word_t h,
                                input bit typed, input logic [VERDICT_BITS-1:0] want);
        int gap;
        logic [VERDICT_BITS-1:0] expected;
        gap = calm ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sig_r = r;
        sig_s = s;
        hash_value = h;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        expected = typed ? want : predict_verdict(r, s, h);
        pending_verdicts = {pending_verdicts, expected};
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic random_request;
        u64_t k, r, s, h, q;
        int   kind;
        q = (mod_q < 2) ? 2 : mod_q;
        kind = $urandom_range(0, 99);
        r = 0;
        s = 0;
        h = $urandom();
        if (kind < 65)
        begin
            for (int tries = 0; tries < 8 && (r == 0 || s == 0); tries++)
            begin
                k = $urandom_range(1, q - 1);
                r = (mod_p < 2) ? 1 : pow_mod(gen_a, k, mod_p) % q;
                if (h % q == 0)
                    h = h + 1;
                s = (mul_mod(secret_x, r, q) + mul_mod(k, h, q)) % q;
            end
            if (kind >= 50)
            begin
                case ($urandom_range(0, 2))
                    0: s = (s + 1) % q;
                    1: r = (r + 1) % q;
                    default: h = h + 1;
                endcase
            end
        end
        else if (kind < 85)
        begin
            r = $urandom_range(0, q);
            s = $urandom_range(0, q);
            h = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) * q : $urandom_range(0, 64);
        end
        else
        begin
            r = $urandom();
            s = $urandom();
        end
        send_request(word_t'(r), word_t'(s), word_t'(h), 1'b0, VERDICT_VALID);
    endtask

    task automatic run_phase(input u64_t p, input u64_t q, input u64_t a, input int count);
        secret_x = (q < 2) ? 1 : $urandom_range(1, q - 1);
        configure(p, q, a, (p < 2) ? 3 : pow_mod(a, secret_x, p));
        for (int n = 0; n < count; n++)
        begin
            calm = (n % 40) >= 32;
            if (n == count / 2)
                while (pending_verdicts.size() != 0)
                    @(negedge clk);
            random_request();
        end
        calm = 1'b0;
    endtask

    sig_row_t directed[$] = '{
        '{32'd0, 32'd1, 32'd1, 1'b1, VERDICT_R_RANGE},
        '{32'hFFFFFFFF, 32'd1, 32'd1, 1'b1, VERDICT_R_RANGE},
        '{32'd2, 32'd0, 32'd0, 1'b1, VERDICT_R_RANGE},
        '{32'd1, 32'd0, 32'd1, 1'b1, VERDICT_S_RANGE},
        '{32'd1, 32'hFFFFFFFF, 32'd1, 1'b1, VERDICT_S_RANGE},
        '{32'd1, 32'd1, 32'd0, 1'b1, VERDICT_NO_INV},
        '{32'd1, 32'd1, 32'hFFFFFFFE, 1'b1, VERDICT_NO_INV},
        '{32'd1, 32'd1, 32'd1, 1'b1, VERDICT_VALID},
        '{32'd1, 32'd1, 32'hFFFFFFFF, 1'b1, VERDICT_VALID}
    };

    sig_row_t small_rows[$] = '{
        '{32'd0, 32'd5, 32'd3, 1'b1, VERDICT_R_RANGE},
        '{32'd11, 32'd5, 32'd3, 1'b1, VERDICT_R_RANGE},
        '{32'd3, 32'd11, 32'd3, 1'b1, VERDICT_S_RANGE},
        '{32'd3, 32'd5, 32'd22, 1'b1, VERDICT_NO_INV},
        '{32'd10, 32'd10, 32'd1, 1'b0, VERDICT_VALID},
        '{32'd1, 32'd1, 32'hFFFFFFFF, 1'b0, VERDICT_VALID},
        '{32'd7, 32'd2, 32'd9, 1'b0, VERDICT_VALID}
    };

    initial
    begin
        mod_p = 2;
        mod_q = 2;
        gen_a = 1;
        pub_y = 1;
        secret_x = 1;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[i])
            send_request(directed[i].r, directed[i].s, directed[i].h,
                         directed[i].typed, directed[i].want);
        in_valid = 1'b0;
        configure(23, 11, 2, 8);
        foreach (small_rows[i])
            send_request(small_rows[i].r, small_rows[i].s, small_rows[i].h,
                         small_rows[i].typed, small_rows[i].want);
        in_valid = 1'b0;
        run_phase(23, 11, 2, 140);
        run_phase(607, 101, 64, 110);
        run_phase(1, 11, 2, 20);
        run_phase(31, 15, 2, 40);
        run_phase(64'd4294967291, 64'd22605091, pow_mod(2, 190, 64'd4294967291), 30);
        run_phase(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 25);
        run_phase(2, 0, 0, 15);
        in_valid = 1'b0;
        drain();
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        int n;
        forever
        begin
            n = calm ? 0 : $urandom_range(0, 18);
            if (n != 0)
            begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: verdict %0d with none expected", $realtime, verdict);
                failures++;
            end
            else if (verdict !== pending_verdicts[0])
            begin
                $display("%0t: verdict expected %0d actual %0d", $realtime,
                         pending_verdicts[0], verdict);
                failures++;
                void'(pending_verdicts.pop_front());
            end
            else
                void'(pending_verdicts.pop_front());
        end
        if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
`default_nettype wire
